@@ hw/rtl/phtmf_pkg.sv @@
// Package for the pH trimmed-mean filter: state type, register indexes,
// register reset values and the output saturation limits.
// No dependencies.
`timescale 1ns / 1ps

package phtmf_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int SLOPE_W    = 14;
    localparam int OFFSET_W   = 12;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam int SLOPE5_W   = SLOPE_W + 3;
    localparam int SCALE_SHIFT = 10;

    localparam logic [CFG_IDX_W-1:0] REG_PH_SLOPE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PH_OFFSET = 1'b1;

    localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = 14'd3500;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd0;

    localparam int PH_MIN_MILLI  = -2000;
    localparam int PH_MAX_MILLI  = 19500;
    localparam int TRIM_SAT_MAX  = 65535;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_LAST,
        ST_TRIM,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } phtmf_state_t;

endpackage

@@ hw/rtl/phtmf_ifs.sv @@
// Valid/ready channel interfaces for the pH trimmed-mean filter:
// the sample input channel and the result output channel.
// No dependencies.
`timescale 1ns / 1ps

interface phtmf_sample_if;
    logic       valid;
    logic       ready;
    logic [9:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface phtmf_result_if;
    logic               valid;
    logic               ready;
    logic [15:0]        trimmed_sum;
    logic signed [15:0] ph_milli;

    modport source (output valid, output trimmed_sum, output ph_milli, input ready);
    modport sink   (input valid, input trimmed_sum, input ph_milli, output ready);
endinterface

@@ hw/rtl/phtmf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module phtmf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 40
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/phtmf_div.sv @@
// Divider by a fixed divisor: multiply by the rounded-up reciprocal, then shift.
// Quotient is ready in the cycle after start and holds until the next start.
// No dependencies.
`timescale 1ns / 1ps

module phtmf_div #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR    = 38
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int SHW = $clog2(DIVISOR);
    localparam int MW  = DIVIDEND_W + 2;
    localparam int PRW = DIVIDEND_W + MW;
    // ceil(2^(DIVIDEND_W + SHW) / DIVISOR) is exact for every dividend of DIVIDEND_W bits
    localparam longint unsigned MAGIC_FULL =
        ((64'd1 << (DIVIDEND_W + SHW)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] MAGIC = MW'(MAGIC_FULL);

    logic           done_reg;
    logic [PRW-1:0] prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PRW'(dividend) * PRW'(MAGIC);
        end
    end

    assign done     = done_reg;
    assign quotient = DIVIDEND_W'(prod_reg >> (DIVIDEND_W + SHW));

endmodule

@@ hw/rtl/ph_trimmed_mean_filter_core.sv @@
// Each accepted sample is written into a ring RAM of NUM_SAMPLES entries;
// the ring is then read back one entry per cycle to form the sum less one
// minimum and one maximum, which is scaled to pH in thousandths by one
// multiply and a reciprocal-multiply divide by (NUM_SAMPLES - 2). A sample is
// handled in turn by the ring walk through the single RAM read port, the last
// read, the trim, the product, the divide and the emit; no new sample is taken
// until it is emitted, and the emit waits while an earlier result is unread.
// Unwritten ring entries read as zero through a fill count, so no clearing
// pass is needed after reset. A finished result waits in an output register,
// and the next sample may be taken while it waits. Register 0 is the slope
// (pH per volt in thousandths), register 1 the signed offset; write them only
// while the block is idle.
// Depends on phtmf_pkg, phtmf_ifs, phtmf_ram and phtmf_div.
`timescale 1ns / 1ps

module ph_trimmed_mean_filter_core
    import phtmf_pkg::*;
#(
    parameter int NUM_SAMPLES = 40
) (
    input  logic                  clk,
    input  logic                  rst_n,
    phtmf_sample_if.sink          sample,
    phtmf_result_if.source        result,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(NUM_SAMPLES);
    localparam int FW = $clog2(NUM_SAMPLES + 1);
    localparam int SW = $clog2(((1 << SAMPLE_W) - 1) * NUM_SAMPLES + 1);
    localparam int PW = SW + SLOPE5_W;
    localparam int QW = PW - SCALE_SHIFT;
    localparam int HW = QW + 2;
    localparam int CW = (SW > OUT_W) ? SW : OUT_W;

    phtmf_state_t state_reg, state_next;

    logic [SLOPE_W-1:0]  slope_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [AW-1:0]       write_slot_reg;
    logic [FW-1:0]       fill_reg;
    logic [AW-1:0]       rd_idx_reg;
    logic                pend_reg;
    logic                live_reg;
    logic                out_valid_reg;

    logic [SW-1:0]       sum_reg;
    logic [SAMPLE_W-1:0] lo_reg;
    logic [SAMPLE_W-1:0] hi_reg;
    logic [SW-1:0]       trim_reg;
    logic [SLOPE5_W-1:0] slope5_reg;
    logic [PW-1:0]       prod_reg;
    logic [OUT_W-1:0]    out_trim_reg;
    logic [OUT_W-1:0]    out_ph_reg;

    logic                in_xfer;
    logic                out_xfer;
    logic                emit;
    logic                walk_last;
    logic                div_start;
    logic                div_done;
    logic [QW-1:0]       quot;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0] samp;
    logic [HW-1:0]       ph_wide;
    logic [OUT_W-1:0]    ph_sat;
    logic [CW-1:0]       trim_ext;
    logic [OUT_W-1:0]    trim_sat;

    assign in_xfer   = sample.valid & sample.ready;
    assign out_xfer  = result.valid & result.ready;
    assign walk_last = (rd_idx_reg == AW'(NUM_SAMPLES - 1));
    // product is registered by the time the divide starts
    assign div_start = (state_reg == ST_DIV) && !div_done;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (sample.valid) state_next = ST_WALK;
            ST_WALK: if (walk_last) state_next = ST_LAST;
            ST_LAST: state_next = ST_TRIM;
            ST_TRIM: state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_EMIT;
            ST_EMIT: if (!out_valid_reg || result.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        sample.ready = 1'b0;
        emit         = 1'b0;
        case (state_reg)
            ST_IDLE: sample.ready = 1'b1;
            ST_EMIT: emit = !out_valid_reg || result.ready;
            default:
            begin
                sample.ready = 1'b0;
                emit         = 1'b0;
            end
        endcase
    end

    phtmf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NUM_SAMPLES)
    ) u_ring (
        .clk   (clk),
        .we    (in_xfer),
        .waddr (write_slot_reg),
        .wdata (sample.adc_sample),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    phtmf_div #(
        .DIVIDEND_W (QW),
        .DIVISOR    (NUM_SAMPLES - 2)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[PW-1:SCALE_SHIFT]),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slope_reg      <= SLOPE_RESET;
            offset_reg     <= OFFSET_RESET;
            write_slot_reg <= '0;
            fill_reg       <= '0;
            rd_idx_reg     <= '0;
            pend_reg       <= 1'b0;
            live_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_PH_SLOPE:  slope_reg  <= cfg_data[SLOPE_W-1:0];
                    REG_PH_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
                    default:       slope_reg  <= slope_reg;
                endcase
            end
            if (in_xfer)
            begin
                write_slot_reg <= (write_slot_reg == AW'(NUM_SAMPLES - 1)) ?
                                  '0 : write_slot_reg + 1'b1;
                if (fill_reg != FW'(NUM_SAMPLES))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                rd_idx_reg <= '0;
            end
            else if (state_reg == ST_WALK && !walk_last)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            pend_reg <= (state_reg == ST_WALK);
            // entries at or beyond the fill count were never written: they read as zero
            live_reg <= (FW'(rd_idx_reg) < fill_reg);
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign samp = live_reg ? ram_rdata : '0;

    always_comb
    begin
        ph_wide = HW'(quot) + {{(HW - OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg};
        if ($signed(ph_wide) < $signed(HW'(PH_MIN_MILLI)))
        begin
            ph_sat = OUT_W'(PH_MIN_MILLI);
        end
        else if ($signed(ph_wide) > $signed(HW'(PH_MAX_MILLI)))
        begin
            ph_sat = OUT_W'(PH_MAX_MILLI);
        end
        else
        begin
            ph_sat = ph_wide[OUT_W-1:0];
        end
        trim_ext = CW'(trim_reg);
        trim_sat = (trim_ext > CW'(TRIM_SAT_MAX)) ? OUT_W'(TRIM_SAT_MAX) :
                   trim_ext[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sum_reg <= '0;
            lo_reg  <= '1;
            hi_reg  <= '0;
        end
        else if (pend_reg)
        begin
            sum_reg <= sum_reg + SW'(samp);
            if (samp < lo_reg)
            begin
                lo_reg <= samp;
            end
            if (samp > hi_reg)
            begin
                hi_reg <= samp;
            end
        end
        if (state_reg == ST_TRIM)
        begin
            trim_reg   <= sum_reg - SW'(lo_reg) - SW'(hi_reg);
            slope5_reg <= SLOPE5_W'({slope_reg, 2'b00}) + SLOPE5_W'(slope_reg);
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PW'(trim_reg) * PW'(slope5_reg);
        end
        if (emit)
        begin
            out_trim_reg <= trim_sat;
            out_ph_reg   <= ph_sat;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.trimmed_sum = out_trim_reg;
    assign result.ph_milli    = $signed(out_ph_reg);

endmodule

@@ bench/testbench.sv @@
// Testbench for ph_trimmed_mean_filter_core: random and directed probe samples
// over valid/ready channels, checked against an in-bench ring-buffer predictor.
// Depends on phtmf_pkg, phtmf_ifs and the filter core RTL.
`timescale 1ns / 1ps

module testbench;
    import phtmf_pkg::*;

    localparam int RING_DEPTH = 40;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        logic [OUT_W-1:0]        trimmed_sum;
        logic signed [OUT_W-1:0] ph_milli;
    } reading_t;

    // Ring-buffer trimmed mean and pH scaling, kept in step with the block
    class ph_reading_predictor;
        bit [SAMPLE_W-1:0]       ring [RING_DEPTH];
        int unsigned             slot;
        logic [SLOPE_W-1:0]      slope;
        logic signed [OFFSET_W-1:0] offset;
        reading_t                pending_readings[$];
        int unsigned             mismatches;

        function new;
            foreach (ring[k])
            begin
                ring[k] = '0;
            end
            slot       = 0;
            slope      = SLOPE_RESET;
            offset     = OFFSET_RESET;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PH_SLOPE:  slope = data[SLOPE_W-1:0];
                REG_PH_OFFSET: offset = data[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_sample(bit [SAMPLE_W-1:0] s);
            int unsigned total;
            int unsigned lo;
            int unsigned hi;
            longint      quot;
            longint      ph;
            reading_t    r;
            ring[slot] = s;
            slot = (slot == RING_DEPTH - 1) ? 0 : slot + 1;
            total = 0;
            lo    = 1023;
            hi    = 0;
            foreach (ring[k])
            begin
                total += ring[k];
                if (ring[k] < lo) lo = ring[k];
                if (ring[k] > hi) hi = ring[k];
            end
            total = total - lo - hi;
            quot = (longint'(total) * 5 * longint'(slope)) / (1024 * (RING_DEPTH - 2));
            if (quot > 1000000) quot = 1000000;
            ph = quot + longint'(offset);
            if (ph < PH_MIN_MILLI) ph = PH_MIN_MILLI;
            if (ph > PH_MAX_MILLI) ph = PH_MAX_MILLI;
            r.trimmed_sum = (total > TRIM_SAT_MAX) ? 16'hFFFF : total[OUT_W-1:0];
            r.ph_milli    = ph[OUT_W-1:0];
            pending_readings.push_back(r);
        endfunction

        function void check_reading(logic [OUT_W-1:0] ts, logic signed [OUT_W-1:0] ph);
            reading_t want;
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: unexpected reading trimmed_sum=%0d ph_milli=%0d",
                             $realtime, ts, ph);
                return;
            end
            want = pending_readings.pop_front();
            if (ts !== want.trimmed_sum || ph !== want.ph_milli)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: mismatch trimmed_sum exp %0d got %0d, ph_milli exp %0d got %0d",
                             $realtime, want.trimmed_sum, ts, want.ph_milli, ph);
            end
        endfunction

        function int pending();
            return pending_readings.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    phtmf_sample_if smp ();
    phtmf_result_if res ();

    ph_reading_predictor pred;

    bit gaps_on;
    bit stall_req;

    ph_trimmed_mean_filter_core #(
        .NUM_SAMPLES(RING_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp),
        .result    (res),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                res.ready <= 1'b0;
                repeat (300) @(negedge clk);
                stall_req = 1'b0;
            end
            else
            begin
                res.ready <= !gaps_on || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            pred.check_reading(res.trimmed_sum, res.ph_milli);
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_sample(bit [SAMPLE_W-1:0] s);
        while (gaps_on && $urandom_range(0, 99) < 20)
        begin
            smp.valid <= 1'b0;
            @(negedge clk);
        end
        smp.valid      <= 1'b1;
        smp.adc_sample <= s;
        do
            @(posedge clk);
        while (!smp.ready);
        pred.take_sample(s);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        smp.valid <= 1'b0;
        while (pred.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        pred.set_register(idx, data);
        @(negedge clk);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] slope, logic [CFG_DATA_W-1:0] offset);
        write_reg(REG_PH_SLOPE, slope);
        write_reg(REG_PH_OFFSET, offset);
        cfg_wen <= 1'b0;
    endtask

    initial
    begin
        bit [SAMPLE_W-1:0] warmup_samples[$];
        bit [SAMPLE_W-1:0] s;
        bit [SAMPLE_W-1:0] prev;
        int                center;
        int                pick;
        pred           = new;
        gaps_on        = 1'b1;
        stall_req      = 1'b0;
        rst_n          = 1'b0;
        cfg_wen        = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        smp.valid      = 1'b0;
        smp.adc_sample = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset config; ring partly zero, extremes and ties
        warmup_samples = '{10'd1023, 10'd1023, 10'd0, 10'd1023, 10'd512, 10'd512,
                           10'd1, 10'd1022, 10'd341, 10'd682, 10'd1023, 10'd1023};
        foreach (warmup_samples[k])
            send_sample(warmup_samples[k]);
        wait_drained();

        // Max slope and offset: pH clips high
        set_config(14'd16383, 14'd2047);
        repeat (4) send_sample(10'd1023);
        wait_drained();

        // Zero slope, most negative offset (junk in the unused upper bits): clips low
        set_config(14'd0, 14'h3800);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd700);
        wait_drained();

        prev   = '0;
        center = 400;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_config(SLOPE_RESET, OFFSET_RESET);
                1: set_config(14'd16383, 14'd2047);
                2: set_config(14'd0, 14'h0800);
                3: set_config(14'd10000, 14'(-2000));
                4: set_config(14'd10000, 14'd2000);
                default: set_config(14'($urandom_range(0, 16383)), 14'($urandom));
            endcase
            gaps_on = (phase != 4);
            for (int n = 0; n < 100; n++)
            begin
                if (phase == 2 && n == 10)
                    stall_req = 1'b1;
                if (phase == 2 && n == 50)
                    wait_drained();
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    s = 10'($urandom);
                else if (pick < 75)
                begin
                    // slow drift, like a settled probe
                    center = center + $urandom_range(0, 20) - 10;
                    if (center < 8) center = 8;
                    if (center > 1015) center = 1015;
                    s = 10'(center + $urandom_range(0, 16) - 8);
                end
                else if (pick < 88)
                    s = ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
                else
                    s = prev;
                send_sample(s);
                prev = s;
            end
            wait_drained();
        end

        gaps_on = 1'b1;
        smp.valid <= 1'b0;
        while (pred.pending() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
        if (pred.mismatches == 0 && pred.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/phtmf_pkg.sv
hw/rtl/phtmf_ifs.sv
hw/rtl/phtmf_ram.sv
hw/rtl/phtmf_div.sv
hw/rtl/ph_trimmed_mean_filter_core.sv
bench/testbench.sv
